// ===== rtl/kmc_pkg.sv =====
// Shared types and constants of the k-way merge compaction core.
`timescale 1ns / 1ps

package kmc_pkg;

   localparam int KEY_W    = 64;
   localparam int RUN_W    = 4;
   localparam int NRUNS_W  = 5;
   localparam int COUNT_W  = 32;
   localparam int MAX_CAP  = 16;

   localparam int REQ_DATA_W = 128;
   localparam int REQ_USER_W = 5;
   localparam int RSP_DATA_W = 168;

   localparam logic [KEY_W-1:0]   TOMBSTONE = 64'hFFFF_FFFF_FFFF_FFFE;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

   localparam int  CSR_ADDR_W       = 3;
   localparam logic CSR_IDX_NUM_RUNS = 1'b0;
   localparam logic [NRUNS_W-1:0] NUM_RUNS_RESET = 5'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_FINISH,
      ST_PUSH
   } kmc_state_type;

   typedef struct packed {
      logic capture;
      logic reject;
      logic write_head;
      logic scan_start;
      logic scan_step;
      logic finish;
      logic push;
   } kmc_cmd_type;

   typedef struct packed {
      logic finished;
      logic mismatch;
      logic fill_more;
      logic scan_last;
      logic out_free;
   } kmc_status_type;

endpackage

// ===== rtl/kmc_csr.sv =====
// Configuration register block holding the run count.
`timescale 1ns / 1ps

module kmc_csr
   import kmc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output logic [NRUNS_W-1:0]    num_runs
);

   logic [NRUNS_W-1:0] num_runs_ff;
   logic [NRUNS_W-1:0] num_runs_in;
   logic               hit;

   assign hit = (csr_paddr[2] == CSR_IDX_NUM_RUNS);

   always_comb begin
      num_runs_in = num_runs_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         num_runs_in = csr_pwdata[NRUNS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_runs_ff <= NUM_RUNS_RESET;
      end else begin
         num_runs_ff <= num_runs_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = hit ? {{(32-NRUNS_W){1'b0}}, num_runs_ff} : 32'd0;
   assign num_runs   = num_runs_ff;

endmodule

// ===== rtl/kmc_ctrl.sv =====
// Sequencing state machine of the merge core.
`timescale 1ns / 1ps

module kmc_ctrl
   import kmc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  kmc_status_type status,
   output kmc_cmd_type    cmd
);

   kmc_state_type state_ff;
   kmc_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.finished || status.mismatch) begin
               cmd.reject = 1'b1;
               state_in   = ST_PUSH;
            end else begin
               cmd.write_head = 1'b1;
               if (status.fill_more) begin
                  state_in = ST_PUSH;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_PUSH;
         end
         ST_PUSH: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/kmc_datapath.sv =====
// Head storage, minimum scan, dedup logic and output register of the merge core.
`timescale 1ns / 1ps

module kmc_datapath
   import kmc_pkg::*;
#(
   parameter int RUNS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [NRUNS_W-1:0]    num_runs,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   input  kmc_cmd_type           cmd,
   output kmc_status_type        status
);

   localparam int CAP   = (RUNS < MAX_CAP) ? RUNS : MAX_CAP;
   localparam int IDX_W = $clog2(CAP);
   localparam logic [NRUNS_W-1:0] CAP_N = NRUNS_W'(CAP);

   // Captured input transfer.
   logic [RUN_W-1:0] in_run_ff;
   logic [KEY_W-1:0] in_key_ff;
   logic [KEY_W-1:0] in_value_ff;
   logic             in_eor_ff;

   // Head entries; live bits are the only part cleared by reset.
   logic [KEY_W-1:0] head_key_mem   [CAP];
   logic [KEY_W-1:0] head_value_mem [CAP];
   logic [CAP-1:0]   live_ff;

   logic [NRUNS_W-1:0] heads_loaded_ff;
   logic [RUN_W-1:0]   pending_ff;
   logic [KEY_W-1:0]   prev_key_ff;
   logic               prev_valid_ff;
   logic [COUNT_W-1:0] total_ff;
   logic               finished_ff;

   // Scan state.
   logic [IDX_W-1:0] scan_idx_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [KEY_W-1:0] best_key_ff;
   logic [KEY_W-1:0] best_value_ff;
   logic             found_ff;

   // Result staging and output register.
   logic               stg_emit_ff;
   logic [KEY_W-1:0]   stg_key_ff;
   logic [KEY_W-1:0]   stg_value_ff;
   logic               stg_req_ff;
   logic [RUN_W-1:0]   stg_run_ff;
   logic               stg_done_ff;
   logic [COUNT_W-1:0] stg_count_ff;
   logic               rsp_valid_ff;
   logic               rsp_emit_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [NRUNS_W-1:0] n_act;
   logic               filling;
   logic [RUN_W-1:0]   awaited;
   logic [NRUNS_W-1:0] loaded_next;
   logic [IDX_W-1:0]   in_idx;
   logic               cur_live;
   logic [KEY_W-1:0]   cur_key;
   logic               take;
   logic               dup;
   logic               emit_now;
   logic [COUNT_W-1:0] total_next;

   always_comb begin
      if (num_runs < NRUNS_W'(2)) begin
         n_act = NRUNS_W'(2);
      end else if (num_runs > CAP_N) begin
         n_act = CAP_N;
      end else begin
         n_act = num_runs;
      end
   end

   assign filling     = heads_loaded_ff < n_act;
   assign awaited     = filling ? heads_loaded_ff[RUN_W-1:0] : pending_ff;
   assign loaded_next = heads_loaded_ff + NRUNS_W'(1);
   assign in_idx      = in_run_ff[IDX_W-1:0];

   assign cur_live = live_ff[scan_idx_ff];
   assign cur_key  = head_key_mem[scan_idx_ff];
   assign take     = cur_live && (!found_ff || ($signed(cur_key) < $signed(best_key_ff)));

   assign dup        = prev_valid_ff && (best_key_ff == prev_key_ff);
   assign emit_now   = !dup && (best_value_ff != TOMBSTONE);
   assign total_next = (emit_now && (total_ff != COUNT_MAX)) ? total_ff + COUNT_W'(1)
                                                              : total_ff;

   always_comb begin
      status           = '0;
      status.finished  = finished_ff;
      status.mismatch  = (in_run_ff != awaited);
      status.fill_more = filling && (loaded_next < n_act);
      status.scan_last = ({{(NRUNS_W-IDX_W){1'b0}}, scan_idx_ff} == (n_act - NRUNS_W'(1)));
      status.out_free  = !rsp_valid_ff || rsp_tready;
   end

   // Input capture and head storage.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_run_ff   <= req_tuser[RUN_W-1:0];
         in_eor_ff   <= req_tuser[RUN_W];
         in_key_ff   <= req_tdata[KEY_W-1:0];
         in_value_ff <= req_tdata[2*KEY_W-1:KEY_W];
      end
      if (cmd.write_head && !in_eor_ff) begin
         head_key_mem[in_idx]   <= in_key_ff;
         head_value_mem[in_idx] <= in_value_ff;
      end
   end

   // Merge control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff         <= '0;
         heads_loaded_ff <= '0;
         pending_ff      <= '0;
         prev_key_ff     <= '0;
         prev_valid_ff   <= 1'b0;
         total_ff        <= '0;
         finished_ff     <= 1'b0;
         found_ff        <= 1'b0;
         scan_idx_ff     <= '0;
      end else begin
         if (cmd.write_head) begin
            live_ff[in_idx] <= !in_eor_ff;
            if (filling) begin
               heads_loaded_ff <= loaded_next;
            end
         end
         if (cmd.scan_start) begin
            scan_idx_ff <= '0;
            found_ff    <= 1'b0;
         end
         if (cmd.scan_step) begin
            scan_idx_ff <= scan_idx_ff + IDX_W'(1);
            if (take) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.finish) begin
            if (!found_ff) begin
               finished_ff <= 1'b1;
            end else begin
               prev_key_ff          <= best_key_ff;
               prev_valid_ff        <= 1'b1;
               total_ff             <= total_next;
               live_ff[best_idx_ff] <= 1'b0;
               pending_ff           <= {{(RUN_W-IDX_W){1'b0}}, best_idx_ff};
            end
         end
      end
   end

   // Best candidate of the running scan.
   always_ff @(posedge clock) begin
      if (cmd.scan_step && take) begin
         best_idx_ff   <= scan_idx_ff;
         best_key_ff   <= cur_key;
         best_value_ff <= head_value_mem[scan_idx_ff];
      end
   end

   // Result staging.
   always_ff @(posedge clock) begin
      if (cmd.reject) begin
         stg_emit_ff  <= 1'b0;
         stg_key_ff   <= '0;
         stg_value_ff <= '0;
         stg_req_ff   <= !finished_ff;
         stg_run_ff   <= finished_ff ? '0 : awaited;
         stg_done_ff  <= finished_ff;
         stg_count_ff <= total_ff;
      end else if (cmd.write_head) begin
         stg_emit_ff  <= 1'b0;
         stg_key_ff   <= '0;
         stg_value_ff <= '0;
         stg_req_ff   <= 1'b1;
         stg_run_ff   <= loaded_next[RUN_W-1:0];
         stg_done_ff  <= 1'b0;
         stg_count_ff <= total_ff;
      end else if (cmd.finish) begin
         if (!found_ff) begin
            stg_emit_ff  <= 1'b0;
            stg_key_ff   <= '0;
            stg_value_ff <= '0;
            stg_req_ff   <= 1'b0;
            stg_run_ff   <= '0;
            stg_done_ff  <= 1'b1;
            stg_count_ff <= total_ff;
         end else begin
            stg_emit_ff  <= emit_now;
            stg_key_ff   <= emit_now ? best_key_ff : '0;
            stg_value_ff <= emit_now ? best_value_ff : '0;
            stg_req_ff   <= 1'b1;
            stg_run_ff   <= {{(RUN_W-IDX_W){1'b0}}, best_idx_ff};
            stg_done_ff  <= 1'b0;
            stg_count_ff <= total_next;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_emit_ff <= stg_emit_ff;
         rsp_data_ff <= {2'b00, stg_count_ff, stg_done_ff, stg_run_ff, stg_req_ff,
                         stg_value_ff, stg_key_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_emit_ff;

endmodule

// ===== rtl/kway_merge_compaction_core.sv =====
// Top level of the k-way merge compaction core.
// A rejected or fill-phase input transfer passes through capture, check and push; one
// that triggers a pick passes through capture, check, scan, finish and push. A new input
// transfer is taken only after the previous result has been pushed to the output register,
// and the pick scans the run heads one per cycle through one head read port.
// Reset (synchronous, active high) clears control state and sets the run count to 2.
`timescale 1ns / 1ps

module kway_merge_compaction_core
   import kmc_pkg::*;
#(
   parameter int RUNS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,

   // Input channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata, from bit 0: key[63:0], value[127:64].
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser, from bit 0: run_index[3:0], end_of_run[4].
   input  logic [REQ_USER_W-1:0] req_tuser,

   // Result channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata, from bit 0: out_key[63:0], out_value[127:64], request_valid[128],
   // request_run[132:129], done_res[133], entries_written[165:134], zero fill.
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // tuser, from bit 0: emit[0].
   output logic                  rsp_tuser,

   // Configuration port; register num_runs at byte address 0.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // The controller steps through capture, check, scan, finish and push; the
   // datapath holds the run heads and performs one comparison per scan cycle.
   // The output register lets a new input transfer be taken while a result
   // still waits downstream; the push step stalls only if it is still full.

   logic [NRUNS_W-1:0] num_runs;
   kmc_cmd_type        cmd;
   kmc_status_type     status;

   kmc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .num_runs    (num_runs)
   );

   kmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kmc_datapath #(
      .RUNS (RUNS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .num_runs   (num_runs),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// ===== dv/tb_kway_merge_compaction_core.sv =====
// Self-checking testbench for the k-way merge compaction core.
`timescale 1ns / 1ps

module tb_kway_merge_compaction_core;
   import kmc_pkg::*;

   localparam int MERGE_RUNS      = 16;
   localparam int RUN_CAP         = (MERGE_RUNS < MAX_CAP) ? MERGE_RUNS : MAX_CAP;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_OFF_CYCLES = 400;
   // Long enough to cover the worst pick, both to its result and to the next input.
   localparam int SETTLE_CYCLES   = 2 * MAX_CAP + 8;
   localparam logic [CSR_ADDR_W-1:0] NUM_RUNS_ADDR = CSR_ADDR_W'(4 * CSR_IDX_NUM_RUNS);

   localparam logic [KEY_W-1:0] KEY_MIN  = 64'h8000_0000_0000_0000;
   localparam logic [KEY_W-1:0] KEY_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [KEY_W-1:0] KEY_NEG5 = 64'hFFFF_FFFF_FFFF_FFFB;
   localparam logic [KEY_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   // One entry (or end marker) offered on the input channel.
   typedef struct packed {
      logic [RUN_W-1:0]   run;
      logic [KEY_W-1:0]   key;
      logic [KEY_W-1:0]   value;
      logic               eor;
   } merge_entry_type;

   // One result transfer, split into its fields.
   typedef struct packed {
      logic               emit;
      logic [KEY_W-1:0]   key;
      logic [KEY_W-1:0]   value;
      logic               req_valid;
      logic [RUN_W-1:0]   req_run;
      logic               done;
      logic [COUNT_W-1:0] written;
   } merge_result_type;

   // A directed row carries a hand-written result only when typed is set.
   typedef struct packed {
      merge_entry_type    entry;
      logic               typed;
      merge_result_type   want;
   } plan_row_type;

   // Directed opening with the reset run count of two. Run 0 starts at the lowest key,
   // run 1 sits at the highest key, then duplicates, tombstones, stray runs, an equal
   // key on both runs (the lower run index wins) and the end of run 0 are walked through.
   localparam int DIRECTED_ROWS = 17;
   localparam plan_row_type DIRECTED_PLAN [DIRECTED_ROWS] = '{
      '{'{4'd1, 64'd1234, 64'd0, 1'b0}, 1'b1, '{1'b0, 64'd0, 64'd0, 1'b1, 4'd0, 1'b0, 32'd0}},
      '{'{4'd0, KEY_MIN, KEY_MAX, 1'b0}, 1'b1, '{1'b0, 64'd0, 64'd0, 1'b1, 4'd1, 1'b0, 32'd0}},
      '{'{4'd1, KEY_MAX, KEY_MIN, 1'b0}, 1'b1,
        '{1'b1, KEY_MIN, KEY_MAX, 1'b1, 4'd0, 1'b0, 32'd1}},
      '{'{4'd0, KEY_MIN, 64'd5, 1'b0}, 1'b1, '{1'b0, 64'd0, 64'd0, 1'b1, 4'd0, 1'b0, 32'd1}},
      '{'{4'd0, KEY_NEG5, TOMBSTONE, 1'b0}, 1'b1,
        '{1'b0, 64'd0, 64'd0, 1'b1, 4'd0, 1'b0, 32'd1}},
      '{'{4'd0, KEY_NEG5, 64'd1, 1'b0}, 1'b1, '{1'b0, 64'd0, 64'd0, 1'b1, 4'd0, 1'b0, 32'd1}},
      '{'{4'd2, ALL_ONES, ALL_ONES, 1'b1}, 1'b1,
        '{1'b0, 64'd0, 64'd0, 1'b1, 4'd0, 1'b0, 32'd1}},
      '{'{4'd0, 64'd0, 64'd0, 1'b0}, 1'b1, '{1'b1, 64'd0, 64'd0, 1'b1, 4'd0, 1'b0, 32'd2}},
      '{'{4'd0, ALL_ONES, ALL_ONES, 1'b0}, 1'b0, '0},
      '{'{4'd0, KEY_MAX, 64'd1, 1'b0}, 1'b1, '{1'b1, KEY_MAX, 64'd1, 1'b1, 4'd0, 1'b0, 32'd4}},
      '{'{4'd0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1}, 1'b1,
        '{1'b0, 64'd0, 64'd0, 1'b1, 4'd1, 1'b0, 32'd4}},
      '{'{4'd0, 64'd5, 64'd5, 1'b0}, 1'b1, '{1'b0, 64'd0, 64'd0, 1'b1, 4'd1, 1'b0, 32'd4}},
      '{'{4'd1, 64'd100, 64'd200, 1'b0}, 1'b0, '0},
      '{'{4'd1, 64'd100, TOMBSTONE, 1'b0}, 1'b0, '0},
      '{'{4'd1, 64'd101, TOMBSTONE, 1'b0}, 1'b0, '0},
      '{'{4'd1, 64'd101, 64'd9, 1'b0}, 1'b0, '0},
      '{'{4'd1, 64'd102, 64'h0123_4567_89AB_CDEF, 1'b0}, 1'b0, '0}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // key[63:0], value[127:64]
   logic [REQ_USER_W-1:0] req_tuser;   // run_index[3:0], end_of_run[4]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // out_key, out_value, request_valid, request_run,
                                       // done_res, entries_written, zero fill
   logic                  rsp_tuser;   // emit[0]
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // Mirror of the merge state, updated at every accepted input transfer.
   logic [KEY_W-1:0]   run_head_key   [MAX_CAP];
   logic [KEY_W-1:0]   run_head_value [MAX_CAP];
   logic               run_head_live  [MAX_CAP] = '{default: 1'b0};
   int                 fill_count     = 0;
   int                 pick_run       = 0;
   logic [KEY_W-1:0]   last_pick_key  = '0;
   logic               last_pick_seen = 1'b0;
   logic [COUNT_W-1:0] emitted_count  = '0;
   logic               merge_done     = 1'b0;
   logic [NRUNS_W-1:0] run_count_reg  = NUM_RUNS_RESET;

   // Last key handed out per run, so that well-formed runs stay sorted.
   logic [KEY_W-1:0]   run_cursor [MAX_CAP];

   merge_result_type   pending_merge_outputs [$];
   int                 mismatch_count = 0;
   int unsigned        cycle_count    = 0;
   logic               quiet_stretch  = 1'b0;
   logic               hold_off_armed = 1'b0;

   kway_merge_compaction_core #(
      .RUNS(MERGE_RUNS)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The run count in use is the register value clamped into 2 .. RUN_CAP.
   function automatic int runs_in_play();
      int n;
      n = int'(run_count_reg);
      if (n < 2) n = 2;
      if (n > RUN_CAP) n = RUN_CAP;
      return n;
   endfunction

   // While heads are still being filled the next run in order is asked for,
   // afterwards the run whose head was picked last.
   function automatic int asked_run_now();
      return (fill_count < runs_in_play()) ? fill_count : pick_run;
   endfunction

   // Applies one accepted input transfer to the mirrored state and returns the result
   // transfer that it must cause.
   function automatic merge_result_type advance_merge(input merge_entry_type e);
      merge_result_type r;
      int               n;
      int               want_run;
      int               best;
      int               i;
      logic             filling;
      logic             found;
      r = '0;
      n = runs_in_play();
      filling = (fill_count < n);
      want_run = filling ? fill_count : pick_run;
      if (!merge_done) begin
         if (int'(e.run) != want_run) begin
            // Stray run: ignored, and the same request goes out again.
            r.req_valid = 1'b1;
            r.req_run = want_run[RUN_W-1:0];
         end else begin
            run_head_live[want_run] = !e.eor;
            if (!e.eor) begin
               run_head_key[want_run] = e.key;
               run_head_value[want_run] = e.value;
            end
            if (filling) fill_count++;
            if (filling && fill_count < n) begin
               r.req_valid = 1'b1;
               r.req_run = fill_count[RUN_W-1:0];
            end else begin
               found = 1'b0;
               best = 0;
               for (i = 0; i < n; i++) begin
                  if (run_head_live[i] &&
                      (!found || $signed(run_head_key[i]) < $signed(run_head_key[best]))) begin
                     best = i;
                     found = 1'b1;
                  end
               end
               if (!found) begin
                  merge_done = 1'b1;
               end else begin
                  r.key = run_head_key[best];
                  r.value = run_head_value[best];
                  if (!(last_pick_seen && r.key == last_pick_key) && r.value != TOMBSTONE) begin
                     r.emit = 1'b1;
                     if (emitted_count != COUNT_MAX) emitted_count++;
                  end
                  last_pick_key = r.key;
                  last_pick_seen = 1'b1;
                  run_head_live[best] = 1'b0;
                  pick_run = best;
                  r.req_valid = 1'b1;
                  r.req_run = best[RUN_W-1:0];
               end
            end
         end
      end
      if (!r.emit) begin
         r.key = '0;
         r.value = '0;
      end
      r.done = merge_done;
      r.written = emitted_count;
      return r;
   endfunction

   // Mostly answers the request with the next sorted entry of that run. A few transfers
   // go to a run that was not asked for, and a few carry an out-of-order key. A run is
   // only ended while two other runs still hold heads, so the merge stays alive.
   function automatic merge_entry_type random_entry();
      merge_entry_type e;
      int              n;
      int              target;
      int              others;
      int              roll;
      int              i;
      n = runs_in_play();
      target = asked_run_now();
      others = 0;
      for (i = 0; i < n; i++)
         if (run_head_live[i] && i != target) others++;
      roll = $urandom_range(0, 99);
      e.key = {$urandom, $urandom};
      e.value = {$urandom, $urandom};
      e.run = target[RUN_W-1:0];
      e.eor = 1'b0;
      if (roll < 7) begin
         e.run = RUN_W'(target + $urandom_range(1, 15));
         e.eor = 1'($urandom_range(0, 1));
      end else if (roll < 12) begin
         e.eor = (others >= 2) && ($urandom_range(0, 3) == 0);
      end else begin
         run_cursor[target] += 64'($urandom_range(0, 3));
         e.key = run_cursor[target];
         e.eor = (others >= 2) && ($urandom_range(0, 99) == 0);
      end
      if ($urandom_range(0, 99) < 12) e.value = TOMBSTONE;
      return e;
   endfunction

   task automatic check_field(input string what, input logic [KEY_W-1:0] want,
                              input logic [KEY_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, actual %h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   // Drives one input transfer, after an optional random gap, and records what it must
   // cause once the block has taken it.
   task automatic offer_entry(input merge_entry_type e, input logic typed,
                              input merge_result_type want);
      merge_result_type predicted;
      while (!quiet_stretch && $urandom_range(0, 99) < 8) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {e.value, e.key};
      req_tuser <= {e.eor, e.run};
      do @(posedge clock); while (!req_tready);
      predicted = advance_merge(e);
      pending_merge_outputs.push_back(typed ? want : predicted);
   endtask

   task automatic run_random(input int count);
      int i;
      for (i = 0; i < count; i++)
         offer_entry(random_entry(), 1'b0, '0);
   endtask

   // Stops offering and waits until every result is back and the block is quiet.
   task automatic settle_merge();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_merge_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes num_runs with a setup and an access cycle, then reads it back.
   task automatic set_run_count(input logic [31:0] word);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= NUM_RUNS_ADDR;
      csr_pwdata <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      run_count_reg = word[NRUNS_W-1:0];
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("num_runs readback", {59'd0, word[NRUNS_W-1:0]}, {32'd0, csr_prdata});
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Result side: ready drops about 8 percent of the time, never during the quiet
   // stretch, and stays low for a long hold-off once the sequence arms it. The hold-off
   // lets the block fill up so that it has to stall the input channel.
   initial begin : result_ready_drive
      int hold_left;
      hold_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (hold_off_armed) begin
            hold_off_armed = 1'b0;
            hold_left = HOLD_OFF_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet_stretch || ($urandom_range(0, 99) >= 8);
         end
      end
   end

   // Every result transfer is matched against the oldest outstanding prediction.
   always @(posedge clock) begin : result_check
      merge_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_merge_outputs.size() == 0) begin
            $display("%0t: result transfer expected none, actual %h / %h",
                     $time, rsp_tuser, rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_merge_outputs.pop_front();
            check_field("emit", {63'd0, want.emit}, {63'd0, rsp_tuser});
            check_field("out_key", want.key, rsp_tdata[63:0]);
            check_field("out_value", want.value, rsp_tdata[127:64]);
            check_field("request_valid", {63'd0, want.req_valid}, {63'd0, rsp_tdata[128]});
            check_field("request_run", {60'd0, want.req_run}, {60'd0, rsp_tdata[132:129]});
            check_field("done_res", {63'd0, want.done}, {63'd0, rsp_tdata[133]});
            check_field("entries_written", {32'd0, want.written}, {32'd0, rsp_tdata[165:134]});
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stimulus
      logic [KEY_W-1:0] base;
      merge_entry_type  closing;
      int               i;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;

      // All runs start from one random key; bit 62 follows the sign so the slow upward
      // walk of the cursors never wraps.
      base = {$urandom, $urandom};
      base[62] = base[63];
      for (i = 0; i < MAX_CAP; i++) run_cursor[i] = base;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_ROWS; i++)
         offer_entry(DIRECTED_PLAN[i].entry, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);

      // The whole run is one merge, since reset is never applied again. Each register
      // change lands mid-merge: growing the count fills the new runs first, shrinking it
      // leaves the upper heads out of the pick until the count grows again.
      settle_merge();
      set_run_count(32'd0);
      run_random(120);

      settle_merge();
      set_run_count(32'd5);
      run_random(200);

      settle_merge();
      set_run_count(32'd16);
      hold_off_armed = 1'b1;
      run_random(300);

      settle_merge();
      set_run_count(32'd31);
      quiet_stretch = 1'b1;
      run_random(200);
      quiet_stretch = 1'b0;

      settle_merge();
      set_run_count(32'd9);
      run_random(200);

      settle_merge();
      set_run_count(32'hFFFF_FFF0);
      run_random(250);

      // End every run that gets asked for until the merge completes, then check that
      // further transfers are ignored, also across one more register change.
      while (!merge_done) begin
         closing.run = RUN_W'(asked_run_now());
         closing.key = {$urandom, $urandom};
         closing.value = {$urandom, $urandom};
         closing.eor = 1'b1;
         offer_entry(closing, 1'b0, '0);
      end
      run_random(8);
      settle_merge();
      set_run_count(32'd1);
      run_random(4);

      settle_merge();
      if (mismatch_count == 0 && pending_merge_outputs.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
